// ----- rtl/core/bpsd_pkg.sv -----
// Shared types and constants for the BMP pixel stream decoder.
`timescale 1ns / 1ps

package bpsd_pkg;

   // Default image size limits.
   localparam int unsigned DEF_MAX_WIDTH  = 4096;
   localparam int unsigned DEF_MAX_HEIGHT = 4096;

   // Header byte positions.
   localparam logic [5:0] HDR_WIDTH_FIRST  = 6'd18;
   localparam logic [5:0] HDR_HEIGHT_FIRST = 6'd22;
   localparam logic [5:0] HDR_HEIGHT_LAST  = 6'd25;
   localparam logic [5:0] HDR_LAST_BYTE    = 6'd53;

   // Result kinds.
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_PIXELS = 2'd1,
      PH_DONE   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      BYTE_BLUE  = 2'd0,
      BYTE_GREEN = 2'd1,
      BYTE_RED   = 2'd2
   } pix_byte_type;

endpackage

// ----- rtl/core/bmp_pixel_stream_decoder.sv -----
// Top level of the BMP pixel stream decoder: header parse, pixel assembly, result register.
`timescale 1ns / 1ps
// A result is presented in the cycle after the request that completes it is accepted.
// Throughput: one byte request per cycle; the result register is refilled in the same cycle
// it is drained, so a request is only held off while a result waits under rsp_stall.
// The parse state and the result register update together from the accepted byte.
// Reset is synchronous and active high; it clears the parse state and the result valid flag,
// after which the decoder expects header byte 0 without needing a start mark.
module bmp_pixel_stream_decoder
   import bpsd_pkg::*;
#(
   parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_file,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [11:0] rsp_row,
   output logic [11:0] rsp_column,
   output logic        rsp_last_pixel
);

   // Counters are sized to hold the largest legal dimension.
   localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
   localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);

   // Parse state.
   phase_type    phase_ff,    phase_in;
   logic [5:0]   hdr_cnt_ff,  hdr_cnt_in;
   logic [31:0]  width_ff,    width_in;
   logic [31:0]  height_ff,   height_in;
   logic [CW-1:0] col_ff,     col_in;
   logic [RW-1:0] row_cnt_ff, row_cnt_in;
   pix_byte_type pix_byte_ff, pix_byte_in;
   logic [7:0]   blue_ff,     blue_in;
   logic [7:0]   green_ff,    green_in;
   logic [1:0]   pad_ff,      pad_in;

   // Result register.
   logic         valid_ff,    valid_in;
   logic         kind_ff,     kind_in;
   logic [7:0]   red_ff,      red_in;
   logic [7:0]   green_o_ff,  green_o_in;
   logic [7:0]   blue_o_ff,   blue_o_in;
   logic [11:0]  row_ff,      row_in;
   logic [11:0]  column_ff,   column_in;
   logic         last_ff,     last_in;

   // Working signals.
   logic         req_fire;
   logic         emit;
   logic         emit_last;
   phase_type    phase_cur;
   logic [5:0]   hdr_cur;
   logic [31:0]  width_cur;
   logic [31:0]  height_cur;
   logic [1:0]   hdr_sel;
   logic         dims_bad;
   logic         row_end;
   logic [31:0]  flip_row;

   // A request is held only while a finished result waits for the consumer.
   assign req_stall = valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;

   always_comb begin
      // A start mark makes this byte header byte 0 of a fresh parse.
      phase_cur  = req_start_of_file ? PH_HEADER : phase_ff;
      hdr_cur    = req_start_of_file ? 6'd0 : hdr_cnt_ff;
      width_cur  = req_start_of_file ? 32'd0 : width_ff;
      height_cur = req_start_of_file ? 32'd0 : height_ff;

      phase_in    = phase_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      col_in      = col_ff;
      row_cnt_in  = row_cnt_ff;
      pix_byte_in = pix_byte_ff;
      blue_in     = blue_ff;
      green_in    = green_ff;
      pad_in      = pad_ff;

      emit       = 1'b0;
      emit_last  = 1'b0;
      kind_in    = KIND_PIXEL;
      red_in     = 8'd0;
      green_o_in = 8'd0;
      blue_o_in  = 8'd0;
      row_in     = 12'd0;
      column_in  = 12'd0;
      hdr_sel    = 2'd0;
      dims_bad   = 1'b0;
      row_end    = 1'b0;
      flip_row   = height_ff - 32'd1 - 32'(row_cnt_ff);

      if (req_fire) begin
         case (phase_cur)
            PH_HEADER: begin
               phase_in  = PH_HEADER;
               width_in  = width_cur;
               height_in = height_cur;
               // Width and height arrive little-endian, one byte per request.
               if (hdr_cur >= HDR_WIDTH_FIRST && hdr_cur < HDR_HEIGHT_FIRST) begin
                  hdr_sel = 2'(hdr_cur - HDR_WIDTH_FIRST);
                  width_in[{hdr_sel, 3'b000} +: 8] = req_data_byte;
               end else if (hdr_cur >= HDR_HEIGHT_FIRST && hdr_cur <= HDR_HEIGHT_LAST) begin
                  hdr_sel = 2'(hdr_cur - HDR_HEIGHT_FIRST);
                  height_in[{hdr_sel, 3'b000} +: 8] = req_data_byte;
               end
               // Negative sizes have bit 31 set and so fail the upper bound too.
               dims_bad = (width_in == 32'd0) || (width_in > 32'(MAX_WIDTH)) ||
                          (height_in == 32'd0) || (height_in > 32'(MAX_HEIGHT));
               if (hdr_cur == HDR_HEIGHT_LAST && dims_bad) begin
                  phase_in   = PH_DONE;
                  hdr_cnt_in = hdr_cur;
                  emit       = 1'b1;
                  emit_last  = 1'b1;
                  kind_in    = KIND_ERROR;
               end else if (hdr_cur >= HDR_LAST_BYTE) begin
                  phase_in    = PH_PIXELS;
                  hdr_cnt_in  = hdr_cur;
                  col_in      = '0;
                  row_cnt_in  = '0;
                  pix_byte_in = BYTE_BLUE;
                  pad_in      = 2'd0;
               end else begin
                  hdr_cnt_in = hdr_cur + 6'd1;
               end
            end
            PH_PIXELS: begin
               if (pad_ff != 2'd0) begin
                  pad_in = pad_ff - 2'd1;
               end else begin
                  case (pix_byte_ff)
                     BYTE_BLUE: begin
                        blue_in     = req_data_byte;
                        pix_byte_in = BYTE_GREEN;
                     end
                     BYTE_GREEN: begin
                        green_in    = req_data_byte;
                        pix_byte_in = BYTE_RED;
                     end
                     default: begin
                        row_end    = (32'(col_ff) + 32'd1) == width_ff;
                        emit_last  = row_end && ((32'(row_cnt_ff) + 32'd1) == height_ff);
                        emit       = 1'b1;
                        red_in     = req_data_byte;
                        green_o_in = green_ff;
                        blue_o_in  = blue_ff;
                        row_in     = flip_row[11:0];
                        column_in  = 12'(32'(col_ff));
                        pix_byte_in = BYTE_BLUE;
                        if (emit_last) begin
                           phase_in = PH_DONE;
                        end else if (row_end) begin
                           col_in     = '0;
                           row_cnt_in = row_cnt_ff + 1'b1;
                           // Rows are padded to four bytes: width mod 4 extra bytes.
                           pad_in     = width_ff[1:0];
                        end else begin
                           col_in = col_ff + 1'b1;
                        end
                     end
                  endcase
               end
            end
            default: begin
               // Done: bytes are dropped until the next start mark.
               phase_in = PH_DONE;
            end
         endcase
      end

      last_in  = emit_last;
      valid_in = emit ? 1'b1 : (valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hdr_cnt_ff  <= 6'd0;
         width_ff    <= 32'd0;
         height_ff   <= 32'd0;
         col_ff      <= '0;
         row_cnt_ff  <= '0;
         pix_byte_ff <= BYTE_BLUE;
         pad_ff      <= 2'd0;
         valid_ff    <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         hdr_cnt_ff  <= hdr_cnt_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_cnt_ff  <= row_cnt_in;
         pix_byte_ff <= pix_byte_in;
         pad_ff      <= pad_in;
         valid_ff    <= valid_in;
      end
   end

   // Held color bytes and the result payload need no reset.
   always_ff @(posedge clock) begin
      blue_ff  <= blue_in;
      green_ff <= green_in;
      if (emit) begin
         kind_ff    <= kind_in;
         red_ff     <= red_in;
         green_o_ff <= green_o_in;
         blue_o_ff  <= blue_o_in;
         row_ff     <= row_in;
         column_ff  <= column_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_red        = red_ff;
   assign rsp_green      = green_o_ff;
   assign rsp_blue       = blue_o_ff;
   assign rsp_row        = row_ff;
   assign rsp_column     = column_ff;
   assign rsp_last_pixel = last_ff;

`ifndef SYNTHESIS
   // While pixels stream, the column stays inside the validated width.
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PIXELS) |-> (32'(col_ff) < width_ff))
      else $error("column counter outside image width");

   // An error result always closes the file and carries a zero position.
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == KIND_ERROR) |-> (last_ff && row_ff == 12'd0 &&
                                               column_ff == 12'd0))
      else $error("error result with pixel fields");

   // Emitting the final pixel or an error moves the parse to done.
   a_last_ends_parse: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_last) |=> (phase_ff == PH_DONE))
      else $error("parse continued after final result");

   // A new result is only loaded when the result register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> !(valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");
`endif

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the BMP pixel stream decoder, driven with whole byte-stream files.
`timescale 1ns / 1ps

module testbench;
   import bpsd_pkg::*;

   // Random files stop once about this many file bytes have been requested, split evenly
   // over the three idle settings.
   localparam int RANDOM_BYTES = 150;

   // One decoded result as the block presents it.
   typedef struct packed {
      logic        kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [11:0] row;
      logic [11:0] column;
      logic        last;
   } pixel_result_type;

   // One file to stream: its header dimensions, whether the first byte carries the start
   // flag, where the file is cut short (0 = never), how many stray bytes follow it, and
   // whether the header error result is typed in here instead of taken from the predictor.
   typedef struct packed {
      logic [31:0] width;
      logic [31:0] height;
      bit          mark;
      int          cut;
      int          trail;
      bit          typed_err;
   } file_case_type;

   // A rejected header always reports the same fixed result.
   localparam pixel_result_type HEADER_ERROR = '{kind: KIND_ERROR, red: 8'd0, green: 8'd0,
      blue: 8'd0, row: 12'd0, column: 12'd0, last: 1'b1};

   // Directed files. The first one has no start flag, right after reset. Then every way a
   // header can be rejected (zero, negative and too large, on either dimension), most of
   // them ending right after the size fields, the widest and the tallest accepted sizes,
   // each cut short after a few pixels, files abandoned in the header and in the pixel data,
   // each row padding length, stray bytes after an image, and a whole file sent without a
   // start flag after a finished image, which must be ignored.
   localparam file_case_type DIRECTED [0:15] = '{
      '{width: 32'd1,          height: 32'd1,          mark: 0, cut: 0,  trail: 0, typed_err: 0},
      '{width: 32'd0,          height: 32'd5,          mark: 1, cut: 0,  trail: 4, typed_err: 1},
      '{width: 32'd3,          height: 32'd0,          mark: 1, cut: 26, trail: 0, typed_err: 1},
      '{width: 32'h8000_0000,  height: 32'd2,          mark: 1, cut: 26, trail: 0, typed_err: 1},
      '{width: 32'd2,          height: 32'hFFFF_FFFF,  mark: 1, cut: 26, trail: 0, typed_err: 1},
      '{width: 32'd4097,       height: 32'd1,          mark: 1, cut: 26, trail: 0, typed_err: 1},
      '{width: 32'd1,          height: 32'd4097,       mark: 1, cut: 26, trail: 0, typed_err: 1},
      '{width: 32'd4096,       height: 32'd1,          mark: 1, cut: 84, trail: 3, typed_err: 0},
      '{width: 32'd1,          height: 32'd4096,       mark: 1, cut: 94, trail: 0, typed_err: 0},
      '{width: 32'd3,          height: 32'd2,          mark: 1, cut: 30, trail: 0, typed_err: 0},
      '{width: 32'd5,          height: 32'd3,          mark: 1, cut: 70, trail: 0, typed_err: 0},
      '{width: 32'd2,          height: 32'd3,          mark: 1, cut: 0,  trail: 0, typed_err: 0},
      '{width: 32'd3,          height: 32'd2,          mark: 1, cut: 0,  trail: 0, typed_err: 0},
      '{width: 32'd4,          height: 32'd2,          mark: 1, cut: 0,  trail: 5, typed_err: 0},
      '{width: 32'd2,          height: 32'd2,          mark: 0, cut: 0,  trail: 0, typed_err: 0},
      '{width: 32'hFFFF_FFFF,  height: 32'hFFFF_FFFF,  mark: 1, cut: 0,  trail: 2, typed_err: 1}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_start_of_file;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [11:0] rsp_row;
   logic [11:0] rsp_column;
   logic        rsp_last_pixel;

   // Chance, in percent per cycle, that the sender idles and that the receiver stalls.
   int send_gap_pct;
   int rcv_stall_pct;

   int errors;
   int file_bytes;
   int files_sent;
   int pixels_seen;
   int header_errors_seen;

   // Results still owed by the decoder, oldest first.
   pixel_result_type expected_pixels [$];

   // Predictor state: the parse position within the file and the pixel assembly.
   phase_type    dec_phase;
   logic [5:0]   hdr_pos;
   logic [31:0]  img_w;
   logic [31:0]  img_h;
   logic [11:0]  col_pos;
   logic [11:0]  file_row;
   pix_byte_type pix_slot;
   logic [7:0]   blue_hold;
   logic [7:0]   green_hold;
   logic [1:0]   pad_left;

   bmp_pixel_stream_decoder DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_start_of_file (req_start_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_row           (rsp_row),
      .rsp_column        (rsp_column),
      .rsp_last_pixel    (rsp_last_pixel)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Puts the predictor back where a new file begins, as reset and the start flag do.
   function automatic void clear_decoder();
      dec_phase  = PH_HEADER;
      hdr_pos    = '0;
      img_w      = '0;
      img_h      = '0;
      col_pos    = '0;
      file_row   = '0;
      pix_slot   = BYTE_BLUE;
      blue_hold  = '0;
      green_hold = '0;
      pad_left   = '0;
   endfunction

   // Advances the predictor by one accepted byte. Returns 1 when the byte completes a
   // result, which is then placed in res.
   function automatic bit decode_byte(input logic [7:0] data, input logic sof,
                                      output pixel_result_type res);
      bit row_done;
      bit img_done;
      res = '0;
      if (sof)
         clear_decoder();
      case (dec_phase)
         PH_HEADER: begin
            // Width and height arrive little-endian, each byte in its own slot.
            if (hdr_pos >= HDR_WIDTH_FIRST && hdr_pos < HDR_HEIGHT_FIRST)
               img_w = img_w | (32'(data) << (8 * (hdr_pos - HDR_WIDTH_FIRST)));
            else if (hdr_pos >= HDR_HEIGHT_FIRST && hdr_pos <= HDR_HEIGHT_LAST)
               img_h = img_h | (32'(data) << (8 * (hdr_pos - HDR_HEIGHT_FIRST)));
            // An unsigned compare also rejects negative sizes.
            if (hdr_pos == HDR_HEIGHT_LAST && (img_w == 0 || img_w > DEF_MAX_WIDTH ||
                img_h == 0 || img_h > DEF_MAX_HEIGHT)) begin
               dec_phase = PH_DONE;
               res = HEADER_ERROR;
               return 1'b1;
            end
            if (hdr_pos >= HDR_LAST_BYTE) begin
               dec_phase = PH_PIXELS;
               col_pos   = '0;
               file_row  = '0;
               pix_slot  = BYTE_BLUE;
               pad_left  = '0;
            end else begin
               hdr_pos = hdr_pos + 6'd1;
            end
            return 1'b0;
         end
         PH_PIXELS: begin
            if (pad_left != 0) begin
               pad_left = pad_left - 2'd1;
               return 1'b0;
            end
            case (pix_slot)
               BYTE_BLUE: begin
                  blue_hold = data;
                  pix_slot  = BYTE_GREEN;
                  return 1'b0;
               end
               BYTE_GREEN: begin
                  green_hold = data;
                  pix_slot   = BYTE_RED;
                  return 1'b0;
               end
               default: begin
                  row_done   = (32'(col_pos) + 1 == img_w);
                  img_done   = row_done && (32'(file_row) + 1 == img_h);
                  res.kind   = KIND_PIXEL;
                  res.red    = data;
                  res.green  = green_hold;
                  res.blue   = blue_hold;
                  res.row    = 12'(img_h - 1 - 32'(file_row));
                  res.column = col_pos;
                  res.last   = img_done;
                  pix_slot   = BYTE_BLUE;
                  if (img_done) begin
                     dec_phase = PH_DONE;
                  end else if (row_done) begin
                     col_pos  = '0;
                     file_row = file_row + 12'd1;
                     pad_left = img_w[1:0];
                  end else begin
                     col_pos = col_pos + 12'd1;
                  end
                  return 1'b1;
               end
            endcase
         end
         default: return 1'b0;
      endcase
   endfunction

   // Offers one byte request, holding it steady until it is taken, and records what the
   // decoder owes for it. Inputs only change right after a rising edge; acceptance is read
   // at the falling edge, where every signal involved is settled.
   task automatic send_byte(input logic [7:0] data, input logic sof, input bit typed_err);
      bit taken;
      bit got;
      pixel_result_type res;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= data;
      req_start_of_file <= sof;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      got = decode_byte(data, sof, res);
      // On a row with a typed-in error, the predictor still tracks the state but the
      // expectation for the last height byte is the fixed error result.
      if (typed_err)
         expected_pixels.push_back(HEADER_ERROR);
      else if (got)
         expected_pixels.push_back(res);
   endtask

   // Streams one file: random filler in the header apart from the size fields, random
   // pixel and padding bytes, then any stray bytes that follow it.
   task automatic send_file(input file_case_type fc);
      int total;
      int w;
      logic [7:0] data;
      bit dims_ok;
      dims_ok = fc.width != 0 && fc.width <= DEF_MAX_WIDTH &&
                fc.height != 0 && fc.height <= DEF_MAX_HEIGHT;
      w = fc.width;
      total = 54 + (dims_ok ? int'(fc.height) * (3 * w + (w & 3)) : 0);
      if (fc.cut != 0 && fc.cut < total)
         total = fc.cut;
      for (int pos = 0; pos < total; pos++) begin
         if (pos >= 18 && pos < 22)
            data = fc.width[8 * (pos - 18) +: 8];
         else if (pos >= 22 && pos < 26)
            data = fc.height[8 * (pos - 22) +: 8];
         else
            data = 8'($urandom_range(255));
         send_byte(data, fc.mark && pos == 0, fc.typed_err && pos == 25);
      end
      for (int i = 0; i < fc.trail; i++)
         send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
      file_bytes += total + fc.trail;
      files_sent++;
   endtask

   // Holds the sender off until the decoder has delivered everything it owes.
   task automatic drain_results();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (expected_pixels.size() != 0);
   endtask

   // A size that the header check must reject: zero, negative or just above the limit.
   function automatic logic [31:0] bad_dim(input int unsigned limit);
      case ($urandom_range(2))
         0:       return 32'd0;
         1:       return 32'h8000_0000 | $urandom;
         default: return limit + 1 + $urandom_range(1000);
      endcase
   endfunction

   task automatic check_field(input string name, input int unsigned want_v,
                              input int unsigned seen_v);
      if (want_v !== seen_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, seen_v);
      end
   endtask

   // The receiver stalls at random, at the rate of the current idle setting.
   always @(posedge clock)
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < rcv_stall_pct);

   // Result checker: a result is taken at the next rising edge when valid is high and
   // stall is low, so it is judged at the falling edge before it.
   always @(negedge clock) begin
      pixel_result_type seen;
      pixel_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_kind, rsp_red, rsp_green, rsp_blue, rsp_row, rsp_column,
                  rsp_last_pixel};
         if (seen.kind == KIND_PIXEL)
            pixels_seen++;
         else
            header_errors_seen++;
         if (expected_pixels.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0d row %0d column %0d",
                     $time, seen.kind, seen.row, seen.column);
         end else begin
            want = expected_pixels.pop_front();
            check_field("kind", want.kind, seen.kind);
            check_field("red", want.red, seen.red);
            check_field("green", want.green, seen.green);
            check_field("blue", want.blue, seen.blue);
            check_field("row", want.row, seen.row);
            check_field("column", want.column, seen.column);
            check_field("last_pixel", want.last, seen.last);
         end
      end
   end

   // Stimulus: reset, the directed files, then random files under three idle settings.
   initial begin
      file_case_type fc;
      int directed_bytes;
      int mode;
      int n;
      int pick;
      errors             = 0;
      file_bytes         = 0;
      files_sent         = 0;
      pixels_seen        = 0;
      header_errors_seen = 0;
      send_gap_pct       = 10;
      rcv_stall_pct      = 47;
      clear_decoder();
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_data_byte     <= 8'd0;
      req_start_of_file <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(DIRECTED); i++)
         send_file(DIRECTED[i]);
      // Let the decoder empty out completely once before the random part.
      drain_results();
      directed_bytes = file_bytes;

      // Mostly well-formed files of small random size, some with rejected headers, some
      // abandoned part way, and some bursts of loose bytes with stray start flags. Every
      // idle setting gets its own share of the byte budget, though one large file can use up later shares.
      for (mode = 0; mode < 3; mode++) begin
         if (mode != 0) begin
            drain_results();
            send_gap_pct  = (mode == 1) ? 47 : 0;
            rcv_stall_pct = (mode == 1) ? 10 : 0;
         end
         while (file_bytes < directed_bytes + (mode + 1) * RANDOM_BYTES / 3) begin
            fc.width     = ($urandom_range(9) == 0) ? $urandom_range(20, 9) :
                                                      $urandom_range(8, 1);
            fc.height    = $urandom_range(5, 1);
            fc.mark      = ($urandom_range(19) != 0);
            fc.cut       = 0;
            fc.trail     = $urandom_range(3);
            fc.typed_err = 1'b0;
            pick = $urandom_range(99);
            if (pick < 12) begin
               if ($urandom_range(1) == 0)
                  fc.width = bad_dim(DEF_MAX_WIDTH);
               else
                  fc.height = bad_dim(DEF_MAX_HEIGHT);
               fc.trail = $urandom_range(8);
            end else if (pick < 22) begin
               n = int'(fc.width);
               fc.cut = $urandom_range(54 + int'(fc.height) * (3 * n + (n & 3)) - 1, 1);
            end else if (pick < 30) begin
               n = $urandom_range(20, 1);
               for (int i = 0; i < n; i++)
                  send_byte(8'($urandom_range(255)), $urandom_range(7) == 0, 1'b0);
               file_bytes += n;
               continue;
            end
            send_file(fc);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("Covered %0d files in %0d file bytes: %0d pixels and %0d header errors checked,",
               files_sent, file_bytes, pixels_seen, header_errors_seen);
      $display("with idling on either side, on both and on neither.");
      if (errors == 0)
         $display("bmp_pixel_stream_decoder verification clean");
      else
         $display("bmp_pixel_stream_decoder verification failed");
      $finish;
   end

   // Watchdog against a hung handshake, far beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("Timeout with %0d results still owed.", expected_pixels.size());
      $display("bmp_pixel_stream_decoder verification failed");
      $finish;
   end

endmodule
